// File: rtl/ucld_pkg.sv
package ucld_pkg;

  localparam logic [7:0] ChBs    = 8'h08;
  localparam logic [7:0] ChDel   = 8'h7f;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChBell  = 8'h07;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChX     = 8'h58;
  localparam logic [31:0] AlignMask = 32'hffff_fffc;

  localparam logic [7:0] OpInfo  = 8'h49;
  localparam logic [7:0] OpDump  = 8'h44;
  localparam logic [7:0] OpRead  = 8'h52;
  localparam logic [7:0] OpWrite = 8'h57;
  localparam logic [7:0] OpGpio  = 8'h47;
  localparam logic [7:0] OpSpi   = 8'h53;

  localparam logic [3:0] CmdInfo   = 4'd0;
  localparam logic [3:0] CmdDump   = 4'd1;
  localparam logic [3:0] CmdRead   = 4'd2;
  localparam logic [3:0] CmdWrite  = 4'd3;
  localparam logic [3:0] CmdGpio   = 4'd4;
  localparam logic [3:0] CmdSpi    = 4'd5;
  localparam logic [3:0] CmdUnk    = 4'd6;
  localparam logic [3:0] CmdRdUse  = 4'd7;
  localparam logic [3:0] CmdWrUse  = 4'd8;

  typedef enum logic [3:0] {
    StIdle, StEcho, StBs1, StBs2, StBs3, StNl, StRead, StScan, StCmd
  } state_e;

  typedef enum logic [3:0] {
    PsLead, PsCmd, PsArgBlank, PsPre0, PsPreX, PsDig, PsDone
  } pstate_e;

  typedef struct packed {
    logic       out_valid;
    logic       out_kind;
    logic [7:0] out_char;
    logic       out_last;
    logic       store;
    logic       len_inc;
    logic       len_dec;
    logic       len_clr;
    logic       scan_start;
    logic       scan_step;
    logic       cmd_commit;
  } ctrl_t;

  typedef struct packed {
    logic len_zero;
    logic len_full;
    logic scan_done;
    logic have_cmd;
  } stat_t;

  function automatic logic [7:0] upper(logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7a) return c - 8'd32;
    return c;
  endfunction

  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [7:0] u;
    u = upper(c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
    if (u >= 8'h41 && u <= 8'h46) return {1'b1, u[3:0] + 4'd9};
    return 5'd0;
  endfunction

endpackage

// File: rtl/ucld_ram.sv
module ucld_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: rtl/ucld_ctrl.sv
module ucld_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     rx_char_i,
  input  logic           out_ready_i,
  input  ucld_pkg::stat_t stat_i,
  output ucld_pkg::ctrl_t ctrl_o,
  output logic           out_valid_o
);
  import ucld_pkg::*;

  state_e state_q, state_d;
  logic [7:0] char_q;
  logic busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) char_q <= rx_char_i;
  end

  assign busy = (state_q != StIdle);
  assign in_ready_o = !busy;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (rx_char_i == ChCr || rx_char_i == ChLf) state_d = StNl;
          else if ((rx_char_i == ChBs || rx_char_i == ChDel) && !stat_i.len_zero)
            state_d = StBs1;
          else state_d = StEcho;
        end
      end
      StEcho: if (out_ready_i) state_d = StIdle;
      StBs1: if (out_ready_i) state_d = StBs2;
      StBs2: if (out_ready_i) state_d = StBs3;
      StBs3: if (out_ready_i) state_d = StIdle;
      StNl: begin
        if (stat_i.len_zero) begin
          if (out_ready_i) state_d = StIdle;
        end else begin
          state_d = StRead;
        end
      end
      StRead: state_d = StScan;
      StScan: begin
        if (stat_i.scan_done) begin
          if (!stat_i.have_cmd) state_d = StEcho;
          else if (out_ready_i) state_d = StCmd;
        end
      end
      StCmd: if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    case (state_q)
      StIdle: begin
        ctrl_o.scan_start = in_valid_i;
      end
      StEcho: begin
        ctrl_o.out_valid = 1'b1;
        ctrl_o.out_last = 1'b1;
        if (char_q == ChCr || char_q == ChLf) ctrl_o.out_char = ChLf;
        else if (stat_i.len_full) ctrl_o.out_char = ChBell;
        else ctrl_o.out_char = char_q;
        if (out_ready_i && !(char_q == ChCr || char_q == ChLf) && !stat_i.len_full) begin
          ctrl_o.store = 1'b1;
          ctrl_o.len_inc = 1'b1;
        end
      end
      StBs1: begin
        ctrl_o.out_valid = 1'b1;
        ctrl_o.out_char = ChBs;
      end
      StBs2: begin
        ctrl_o.out_valid = 1'b1;
        ctrl_o.out_char = ChSpace;
      end
      StBs3: begin
        ctrl_o.out_valid = 1'b1;
        ctrl_o.out_char = ChBs;
        ctrl_o.out_last = 1'b1;
        ctrl_o.len_dec = out_ready_i;
      end
      StNl: begin
        if (stat_i.len_zero) begin
          ctrl_o.out_valid = 1'b1;
          ctrl_o.out_char = ChLf;
          ctrl_o.out_last = 1'b1;
        end
      end
      StRead: ctrl_o.scan_step = 1'b0;
      StScan: begin
        ctrl_o.scan_step = !stat_i.scan_done;
        if (stat_i.scan_done && stat_i.have_cmd) begin
          ctrl_o.out_valid = 1'b1;
          ctrl_o.out_char = ChLf;
          ctrl_o.len_clr = 1'b1;
        end else if (stat_i.scan_done) begin
          ctrl_o.len_clr = 1'b1;
        end
      end
      StCmd: begin
        ctrl_o.out_valid = 1'b1;
        ctrl_o.out_kind = 1'b1;
        ctrl_o.out_last = 1'b1;
        ctrl_o.cmd_commit = out_ready_i;
      end
      default: ctrl_o = '0;
    endcase
  end

  assign out_valid_o = ctrl_o.out_valid;
endmodule

// File: rtl/ucld_dp.sv
module ucld_dp #(
  parameter int LineLen   = 64,
  parameter int DumpCount = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [31:0]     cfg_wdata_i,
  input  ucld_pkg::ctrl_t ctrl_i,
  output ucld_pkg::stat_t stat_o,
  output logic [3:0]      command_code_o,
  output logic [31:0]     target_address_o,
  output logic [31:0]     write_value_o
);
  import ucld_pkg::*;

  localparam int AW = $clog2(LineLen);
  localparam int LW = $clog2(LineLen + 1);
  localparam logic [31:0] DumpStep = 32'(4 * DumpCount);

  logic [LW-1:0] len_q;
  logic [LW-1:0] pos_q, pos_d;
  logic [7:0] rdata;
  logic [AW-1:0] raddr;
  logic [31:0] start_q, dptr_q;
  logic dset_q;
  pstate_e ps_q, ps_d;
  logic [7:0] cmd_q, cmd_d;
  logic [1:0] nargs_q, nargs_d;
  logic [31:0] acc_q, acc_d, a0_q, a0_d, a1_q, a1_d;
  logic got_q, got_d, ended_q, ended_d;
  logic [7:0] ch;
  logic [4:0] hd;
  logic [3:0] code;
  logic [31:0] base;

  ucld_ram #(.Width(8), .Depth(LineLen)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.store),
    .waddr_i (len_q[AW-1:0]),
    .wdata_i (ctrl_i.out_char),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign raddr = pos_d[AW-1:0];
  assign stat_o.len_zero = (len_q == '0);
  assign stat_o.len_full = (len_q >= LW'(LineLen - 1));
  assign stat_o.scan_done = (ps_q == PsDone);
  assign stat_o.have_cmd = (cmd_q != 8'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      start_q <= '0;
      dptr_q <= '0;
      dset_q <= 1'b0;
    end else begin
      if (cfg_we_i) start_q <= cfg_wdata_i;
      if (ctrl_i.len_clr) len_q <= '0;
      else if (ctrl_i.len_inc) len_q <= len_q + 1'b1;
      else if (ctrl_i.len_dec) len_q <= len_q - 1'b1;
      if (ctrl_i.cmd_commit && cmd_q == OpDump) begin
        dptr_q <= base + DumpStep;
        dset_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    ps_q <= ps_d;
    cmd_q <= cmd_d;
    nargs_q <= nargs_d;
    acc_q <= acc_d;
    a0_q <= a0_d;
    a1_q <= a1_d;
    got_q <= got_d;
    ended_q <= ended_d;
  end

  assign ch = (ended_q || pos_q >= len_q || rdata == 8'd0) ? 8'd0 : rdata;
  assign hd = hex_digit(ch);

  always_comb begin
    pos_d = pos_q;
    ps_d = ps_q;
    cmd_d = cmd_q;
    nargs_d = nargs_q;
    acc_d = acc_q;
    a0_d = a0_q;
    a1_d = a1_q;
    got_d = got_q;
    ended_d = ended_q;
    if (ctrl_i.scan_start) begin
      pos_d = '0;
      ps_d = PsLead;
      cmd_d = 8'd0;
      nargs_d = 2'd0;
      got_d = 1'b0;
      acc_d = '0;
      ended_d = 1'b0;
    end else if (ctrl_i.scan_step) begin
      if (ch == 8'd0) ended_d = 1'b1;
      case (ps_q)
        PsLead: begin
          if (ch == ChSpace || ch == ChTab) pos_d = pos_q + 1'b1;
          else if (ch == 8'd0) ps_d = PsDone;
          else begin
            cmd_d = upper(ch);
            pos_d = pos_q + 1'b1;
            ps_d = PsArgBlank;
          end
        end
        PsArgBlank: begin
          if (cmd_q == OpInfo || cmd_q == OpGpio || cmd_q == OpSpi ||
              (cmd_q != OpDump && cmd_q != OpRead && cmd_q != OpWrite) ||
              (cmd_q != OpWrite && nargs_q != 2'd0) || nargs_q == 2'd2) begin
            ps_d = PsDone;
          end else if (ch == ChSpace || ch == ChTab) begin
            pos_d = pos_q + 1'b1;
          end else if (ch == ChZero) begin
            ps_d = PsPre0;
            pos_d = pos_q + 1'b1;
            acc_d = '0;
            got_d = 1'b1;
          end else begin
            ps_d = PsDig;
            acc_d = '0;
            got_d = 1'b0;
          end
        end
        PsPre0: begin
          if (upper(ch) == ChX) begin
            ps_d = PsDig;
            pos_d = pos_q + 1'b1;
            got_d = 1'b0;
          end else begin
            ps_d = PsDig;
          end
        end
        PsDig: begin
          if (hd[4]) begin
            acc_d = {acc_q[27:0], hd[3:0]};
            got_d = 1'b1;
            pos_d = pos_q + 1'b1;
          end else if (!got_q) begin
            ps_d = PsDone;
          end else begin
            if (nargs_q == 2'd0) a0_d = acc_q;
            else a1_d = acc_q;
            nargs_d = nargs_q + 1'b1;
            ps_d = PsArgBlank;
          end
        end
        default: ps_d = PsDone;
      endcase
    end
  end

  assign base = ((cmd_q == OpDump && nargs_q != 2'd0) ? a0_q :
                 (dset_q ? dptr_q : start_q)) & AlignMask;

  always_comb begin
    case (cmd_q)
      OpInfo: code = CmdInfo;
      OpDump: code = CmdDump;
      OpRead: code = (nargs_q != 2'd0) ? CmdRead : CmdRdUse;
      OpWrite: code = (nargs_q == 2'd2) ? CmdWrite : CmdWrUse;
      OpGpio: code = CmdGpio;
      OpSpi: code = CmdSpi;
      default: code = CmdUnk;
    endcase
  end

  assign command_code_o = code;
  assign target_address_o = (code == CmdDump) ? base :
                            (code == CmdRead || code == CmdWrite) ? (a0_q & AlignMask) : '0;
  assign write_value_o = (code == CmdWrite) ? a1_q : '0;
endmodule

// File: rtl/uart_command_line_decoder_core.sv
// Channel  | Handshake                 | Payload
// in       | in_valid_i / in_ready_o   | rx_char_i
// out      | out_valid_o / out_ready_i | result_kind_o .. last_of_run_o
// cfg      | cfg_we_i                  | cfg_wdata_i
// An edit character passes through StEcho, or StBs1, StBs2 and StBs3, each held by output stalls.
// End of line scans the stored line character by character through the
// line RAM's registered read port.
// Reset is asynchronous and clears the line length and dump pointer.
// Input is refused while any result of the previous character is pending.
module uart_command_line_decoder_core #(
  parameter int LINE_LEN   = 64,
  parameter int DUMP_COUNT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_char_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [7:0]  echo_char_o,
  output logic [3:0]  command_code_o,
  output logic [31:0] target_address_o,
  output logic [31:0] write_value_o,
  output logic        last_of_run_o
);
  import ucld_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic [3:0] code;
  logic [31:0] addr, val;

  ucld_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .rx_char_i, .out_ready_i,
    .stat_i(stat), .ctrl_o(ctrl), .out_valid_o
  );

  ucld_dp #(.LineLen(LINE_LEN), .DumpCount(DUMP_COUNT)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .ctrl_i(ctrl),
    .stat_o(stat), .command_code_o(code),
    .target_address_o(addr), .write_value_o(val)
  );

  assign result_kind_o = ctrl.out_kind;
  assign echo_char_o = ctrl.out_kind ? 8'd0 : ctrl.out_char;
  assign command_code_o = ctrl.out_kind ? code : 4'd0;
  assign target_address_o = ctrl.out_kind ? addr : 32'd0;
  assign write_value_o = ctrl.out_kind ? val : 32'd0;
  assign last_of_run_o = ctrl.out_last;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken during output");
  a_cmd_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_kind_o) |-> last_of_run_o) else $error("command not last");
`endif
endmodule
